### rtl/dulp_pkg.sv
// ----------------------------------------------------------------------------
// dulp_pkg: shared types and constants for the double ULP distance/step unit
// Field widths, IEEE double layout constants, decode helpers and the
// record passed from the arithmetic stage to the result stage.
// ----------------------------------------------------------------------------
package dulp_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned MagW   = 63;
  localparam int unsigned FracW  = 52;
  localparam int unsigned ExpW   = 11;
  localparam int unsigned EbitsW = 6;

  localparam logic ActDist = 1'b0;
  localparam logic ActStep = 1'b1;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [MagW-1:0]   mag_t;
  typedef logic [EbitsW-1:0] ebits_t;

  // Arithmetic stage output
  typedef struct packed {
    logic  act;
    word_t value;
    logic  nan;
    logic  ovf;
  } calc_t;

  function automatic logic is_nan(input word_t x);
    return (x[WordW-2 -: ExpW] == {ExpW{1'b1}}) && (x[FracW-1:0] != '0);
  endfunction

  // Index of the highest set bit, 0 when none
  function automatic ebits_t top_index(input word_t v);
    ebits_t idx;
    idx = '0;
    for (int i = 0; i < WordW; i++) begin
      if (v[i]) begin
        idx = EbitsW'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/dulp_if.sv
// ----------------------------------------------------------------------------
// dulp_if: valid/ready channels of the double ULP distance/step unit
// Operand channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface dulp_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  dulp_pkg::word_t   operand_a;
  dulp_pkg::word_t   operand_b;

  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface dulp_out_if;
  logic              valid;
  logic              ready;
  dulp_pkg::word_t   result_value;
  dulp_pkg::ebits_t  error_bits;
  logic              nan_seen;
  logic              step_overflow;

  modport source (output valid, result_value, error_bits, nan_seen, step_overflow,
                  input ready);
  modport sink   (input valid, result_value, error_bits, nan_seen, step_overflow,
                  output ready);
endinterface

### rtl/dulp_calc.sv
// ----------------------------------------------------------------------------
// dulp_calc: key arithmetic for one operand pair
// Distance as a sign-aware add or absolute difference of magnitudes;
// step as a signed-magnitude add of an unsigned offset.
// ----------------------------------------------------------------------------
module dulp_calc (
  input  logic            act,
  input  dulp_pkg::word_t opa,
  input  dulp_pkg::word_t opb,
  output dulp_pkg::calc_t res
);

  dulp_pkg::mag_t  mag_a;
  dulp_pkg::mag_t  mag_b;
  logic            sgn_a;
  logic            sgn_b;
  logic [dulp_pkg::MagW:0] dif_ab;
  logic [dulp_pkg::MagW:0] dif_ba;
  dulp_pkg::word_t sum_ab;
  dulp_pkg::word_t key_gap;
  logic [dulp_pkg::WordW:0] st_sum;
  logic [dulp_pkg::WordW:0] st_dif;
  dulp_pkg::word_t st_rdif;
  logic            st_neg;

  assign mag_a = opa[dulp_pkg::MagW-1:0];
  assign mag_b = opb[dulp_pkg::MagW-1:0];
  assign sgn_a = opa[dulp_pkg::WordW-1];
  assign sgn_b = opb[dulp_pkg::WordW-1];

  // Same sign: keys differ by the magnitude difference; opposite: by the sum
  assign dif_ab = {1'b0, mag_a} - {1'b0, mag_b};
  assign dif_ba = {1'b0, mag_b} - {1'b0, mag_a};
  assign sum_ab = {1'b0, mag_a} + {1'b0, mag_b};

  always_comb begin
    if (sgn_a != sgn_b) begin
      key_gap = sum_ab;
    end else if (dif_ab[dulp_pkg::MagW]) begin
      key_gap = {1'b0, dif_ba[dulp_pkg::MagW-1:0]};
    end else begin
      key_gap = {1'b0, dif_ab[dulp_pkg::MagW-1:0]};
    end
  end

  // Negative zero starts at key 0 like positive zero
  assign st_neg  = sgn_a && (mag_a != '0);
  assign st_sum  = {2'b00, mag_a} + {1'b0, opb};
  assign st_dif  = {1'b0, opb} - {2'b00, mag_a};
  assign st_rdif = {1'b0, mag_a} - opb;

  always_comb begin
    res.act = act;
    res.ovf = 1'b0;
    if (act == dulp_pkg::ActDist) begin
      res.value = key_gap;
      res.nan   = dulp_pkg::is_nan(opa) || dulp_pkg::is_nan(opb);
    end else begin
      res.nan = dulp_pkg::is_nan(opa);
      priority if (!st_neg) begin
        res.value = st_sum[dulp_pkg::WordW-1:0];
        res.ovf   = st_sum[dulp_pkg::WordW] || st_sum[dulp_pkg::WordW-1];
      end else if (!st_dif[dulp_pkg::WordW]) begin
        res.value = st_dif[dulp_pkg::WordW-1:0];
        res.ovf   = st_dif[dulp_pkg::WordW-1];
      end else begin
        res.value = {1'b1, st_rdif[dulp_pkg::MagW-1:0]};
      end
    end
  end

endmodule

### rtl/double_ulp_distance_and_step_unit.sv
// ----------------------------------------------------------------------------
// double_ulp_distance_and_step_unit: ULP distance and ULP step on doubles
// Three-register pipeline: operand register, arithmetic result register,
// output register holding the error width of the distance.
// ----------------------------------------------------------------------------
//   channel  | dir | payload
//   ---------+-----+-----------------------------------------------------
//   in_ch    | in  | action, operand_a, operand_b
//   out_ch   | out | result_value, error_bits, nan_seen, step_overflow
//
// One item per cycle sustained while out_ch.ready stays high; an accepted item
// passes from the operand register through the arithmetic and output
// registers to out_ch.
// Reset (synchronous, active low) empties all stages.
// Each stage advances when the stage after it is empty or moving, so a
// stalled output fills the pipeline before in_ch.ready drops.
// ----------------------------------------------------------------------------
module double_ulp_distance_and_step_unit (
  input  logic       clk,
  input  logic       rst_n,
  dulp_in_if.sink    in_ch,
  dulp_out_if.source out_ch
);

  logic            s1_vld_r;
  logic            s1_act_r;
  dulp_pkg::word_t s1_a_r;
  dulp_pkg::word_t s1_b_r;

  logic            s2_vld_r;
  dulp_pkg::calc_t s2_r;
  dulp_pkg::calc_t s2_nxt;

  logic             out_vld_r;
  dulp_pkg::word_t  out_val_r;
  dulp_pkg::ebits_t out_eb_r;
  dulp_pkg::ebits_t out_eb_nxt;
  logic             out_nan_r;
  logic             out_ovf_r;

  logic out_free;
  logic s2_go;
  logic s2_free;
  logic s1_go;
  logic s1_free;

  assign out_free = !out_vld_r || out_ch.ready;
  assign s2_go    = s2_vld_r && out_free;
  assign s2_free  = !s2_vld_r || s2_go;
  assign s1_go    = s1_vld_r && s2_free;
  assign s1_free  = !s1_vld_r || s1_go;

  assign in_ch.ready = s1_free;

  dulp_calc u_calc (
    .act (s1_act_r),
    .opa (s1_a_r),
    .opb (s1_b_r),
    .res (s2_nxt)
  );

  // Distance is at most 2^64 - 2, so the increment never wraps
  assign out_eb_nxt = (s2_r.act == dulp_pkg::ActDist)
                    ? dulp_pkg::top_index(s2_r.value + dulp_pkg::word_t'(1))
                    : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_vld_r <= in_ch.valid;
      end
      if (s2_free) begin
        s2_vld_r <= s1_vld_r;
      end
      if (out_free) begin
        out_vld_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_free) begin
      s1_act_r <= in_ch.action;
      s1_a_r   <= in_ch.operand_a;
      s1_b_r   <= in_ch.operand_b;
    end
    if (s1_go) begin
      s2_r <= s2_nxt;
    end
    if (s2_go) begin
      out_val_r <= s2_r.value;
      out_eb_r  <= out_eb_nxt;
      out_nan_r <= s2_r.nan;
      out_ovf_r <= s2_r.ovf;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.result_value  = out_val_r;
  assign out_ch.error_bits    = out_eb_r;
  assign out_ch.nan_seen      = out_nan_r;
  assign out_ch.step_overflow = out_ovf_r;

endmodule
